// File: rtl/ppcg_pkg.sv
package ppcg_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned ParW   = 31;
  localparam int unsigned LvlW   = 4;
  localparam int unsigned SchemeW = 2;

  localparam logic [SchemeW-1:0] SCHEME_SIMPLE = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIND  = 4'b0010,
    ST_SPLIT = 4'b0100,
    ST_EMIT  = 4'b1000
  } ppcg_state_e;

  typedef struct packed {
    logic accept;    // capture input word
    logic find;      // register resolution of the held pixel
    logic split;     // register row, column and starting level
    logic load_res;  // load one ancestor into the output register, then step down
    logic load_err;  // load the error word into the output register
  } ppcg_cmd_t;

  typedef struct packed {
    logic err;       // held pixel or scheme is invalid
    logic lvl_zero;  // current emit level is zero
  } ppcg_status_t;

  // First pixel number of level lvl: (4^lvl - 1)/3 = binary 0101..01 with lvl ones.
  function automatic logic [ParW-1:0] level_start(input logic [4:0] lvl);
    logic [ParW-1:0] s;
    s = '0;
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < lvl) begin
        s[2*j] = 1'b1;
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/pixel_parent_chain_generator_core.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------------
// input    | in        | in_valid_i / in_stall_o    | child_pixel_i[31:0] signed
// output   | out       | out_valid_o / out_stall_i  | parent_pixel_o, level_o, error_o, last_o
// config   | in        | pixel_scheme_we_i          | pixel_scheme_i[1:0]
//
// A valid pixel of resolution r passes through one resolution search, one
// row/column split, then r+1 ancestor words, one per cycle unless the output
// stalls, through the single output register. An invalid word yields one error word.
// Reset clears the state machine, the output valid and the scheme (simple).
// A stall on the output holds the emit sequence; the input stalls until the chain ends.
module pixel_parent_chain_generator_core #(
  parameter int unsigned MaxRes = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] child_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] parent_pixel_o,
  output logic [3:0]  level_o,
  output logic        error_o,
  output logic        last_o,
  input  logic        pixel_scheme_we_i,
  input  logic [1:0]  pixel_scheme_i
);
  import ppcg_pkg::*;

  ppcg_cmd_t    cmd;
  ppcg_status_t status;

  // Sequence accept, search, split and emit; own the output valid.
  ppcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the pixel, the scheme register, row/column shifters and the output word.
  ppcg_datapath #(
    .MaxRes (MaxRes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .scheme_we_i (pixel_scheme_we_i),
    .scheme_i    (pixel_scheme_i),
    .pix_i       (child_pixel_i),
    .parent_o    (parent_pixel_o),
    .level_o     (level_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/ppcg_ctrl.sv
module ppcg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  ppcg_pkg::ppcg_status_t status_i,
  output ppcg_pkg::ppcg_cmd_t   cmd_o
);
  import ppcg_pkg::*;

  ppcg_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_FIND;
        end
      end
      ST_FIND: begin
        if (status_i.err) begin
          if (out_free) begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.find = 1'b1;
          state_d    = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_res = 1'b1;
          if (status_i.lvl_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_res || cmd_o.load_err) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_res && cmd_o.load_err))
    else $error("ancestor and error word loaded together");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_o.load_res || cmd_o.load_err))
    else $error("output register overwritten while stalled");

  a_accept_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_FIND))
    else $error("accepted word not followed by resolution search");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_res && status_i.lvl_zero) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("chain did not end after level zero");

endmodule

// File: rtl/ppcg_datapath.sv
module ppcg_datapath #(
  parameter int unsigned MaxRes = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppcg_pkg::ppcg_cmd_t           cmd_i,
  output ppcg_pkg::ppcg_status_t        status_o,
  input  logic                          scheme_we_i,
  input  logic [ppcg_pkg::SchemeW-1:0]  scheme_i,
  input  logic [ppcg_pkg::PixW-1:0]     pix_i,
  output logic [ppcg_pkg::ParW-1:0]     parent_o,
  output logic [ppcg_pkg::LvlW-1:0]     level_o,
  output logic                          error_o,
  output logic                          last_o
);
  import ppcg_pkg::*;

  logic [SchemeW-1:0] scheme_q;
  logic [PixW-1:0]    pix_q;
  logic [LvlW-1:0]    r_q, r_d;
  logic [LvlW-1:0]    lvl_q;
  logic [MaxRes-1:0]  row_q, col_q;
  logic [ParW-1:0]    par_q, par_d;
  logic [LvlW-1:0]    olvl_q;
  logic               oerr_q, olast_q;

  logic [ParW-1:0]    top_start;
  logic [ParW-1:0]    offset, row_full, col_full;

  assign top_start = level_start(5'(MaxRes + 1));

  assign status_o.err = (scheme_q != SCHEME_SIMPLE) || pix_q[PixW-1] ||
                        (pix_q[ParW-1:0] >= top_start);
  assign status_o.lvl_zero = (lvl_q == '0);

  // Resolution: count level starts at or below the pixel.
  always_comb begin
    r_d = '0;
    for (int k = 1; k <= 15; k++) begin
      if ((k <= MaxRes) && (pix_q[ParW-1:0] >= level_start(5'(k)))) begin
        r_d = LvlW'(k);
      end
    end
  end

  assign offset   = pix_q[ParW-1:0] - level_start({1'b0, r_q});
  assign row_full = offset >> r_q;
  assign col_full = offset & ((ParW'(1) << r_q) - ParW'(1));

  // Column is below 2^lvl, so it never overlaps the shifted row.
  assign par_d = level_start({1'b0, lvl_q}) + (ParW'(row_q) << lvl_q) + ParW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SCHEME_SIMPLE;
    end else if (scheme_we_i) begin
      scheme_q <= scheme_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pix_i;
    end
    if (cmd_i.find) begin
      r_q <= r_d;
    end
    if (cmd_i.split) begin
      row_q <= row_full[MaxRes-1:0];
      col_q <= col_full[MaxRes-1:0];
      lvl_q <= r_q;
    end else if (cmd_i.load_res) begin
      row_q <= row_q >> 1;
      col_q <= col_q >> 1;
      lvl_q <= lvl_q - LvlW'(1);
    end
    if (cmd_i.load_res) begin
      par_q   <= par_d;
      olvl_q  <= lvl_q;
      oerr_q  <= 1'b0;
      olast_q <= (lvl_q == '0);
    end else if (cmd_i.load_err) begin
      par_q   <= '0;
      olvl_q  <= '0;
      oerr_q  <= 1'b1;
      olast_q <= 1'b1;
    end
  end

  assign parent_o = par_q;
  assign level_o  = olvl_q;
  assign error_o  = oerr_q;
  assign last_o   = olast_q;

endmodule

// File: bench/tb_pixel_parent_chain_generator_core.sv
module tb_pixel_parent_chain_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ppcg_pkg::*;

  // Top resolution level of the pixelization under test.
  localparam int unsigned TopRes = 15;
  // Longest chain is TopRes+1 words plus search and split; use it for the tail wait.
  localparam int unsigned ChainCycles = TopRes + 5;
  // Length of the forced output hold-off, in cycles.
  localparam int unsigned HoldOffCycles = 400;

  // Scheme codes besides the simple one from the package.
  localparam logic [SchemeW-1:0] SCHEME_HIER     = 2'd1;
  localparam logic [SchemeW-1:0] SCHEME_UNKNOWN  = 2'd2;
  localparam logic [SchemeW-1:0] SCHEME_RESERVED = 2'd3;

  // One output word as the block should present it.
  typedef struct packed {
    logic [ParW-1:0] pixel;
    logic [LvlW-1:0] lvl;
    logic            err;
    logic            is_last;
  } ancestor_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] child_pixel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [30:0] parent_pixel_o;
  logic [3:0]  level_o;
  logic        error_o;
  logic        last_o;
  logic        pixel_scheme_we_i = 1'b0;
  logic [1:0]  pixel_scheme_i = SCHEME_SIMPLE;

  // Bench copy of the scheme register; reset leaves the block in the simple scheme.
  logic [SchemeW-1:0] scheme_setting = SCHEME_SIMPLE;
  // Words still owed by the block, oldest first.
  ancestor_t          expected_ancestors[$];
  int unsigned        fail_count = 0;
  // Random idling on both channels; clear it for a stretch of full-rate traffic.
  logic               gaps_enabled = 1'b1;
  // Set by a test to make the receiver hold off for HoldOffCycles.
  logic               hold_request = 1'b0;
  int unsigned        hold_left = 0;

  pixel_parent_chain_generator_core #(
    .MaxRes(TopRes)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .child_pixel_i    (child_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .parent_pixel_o   (parent_pixel_o),
    .level_o          (level_o),
    .error_o          (error_o),
    .last_o           (last_o),
    .pixel_scheme_we_i(pixel_scheme_we_i),
    .pixel_scheme_i   (pixel_scheme_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or drops words.
  initial begin
    #2_000_000;
    $display("** pixel_parent_chain_generator_core: FAILED **");
    $finish;
  end

  // First pixel number of a level: (4^lvl - 1)/3.
  function automatic longint unsigned first_pixel_of_level(input int unsigned lvl);
    return ((64'd1 << (2 * lvl)) - 64'd1) / 64'd3;
  endfunction

  // Work out the whole ancestor chain of one accepted pixel and queue it.
  function automatic void predict_chain(input logic [31:0] pix);
    ancestor_t         word;
    int unsigned       res;
    int unsigned       sh;
    longint unsigned   p, ofs, row, col, anc;
    p = {32'd0, pix};
    // Bad scheme, negative pixel or pixel past the top level: one error word.
    if (scheme_setting != SCHEME_SIMPLE || pix[31] ||
        p >= first_pixel_of_level(TopRes + 1)) begin
      word = '{pixel: '0, lvl: '0, err: 1'b1, is_last: 1'b1};
      expected_ancestors.push_back(word);
      return;
    end
    res = 0;
    while (res < TopRes && first_pixel_of_level(res + 1) <= p) res++;
    ofs = p - first_pixel_of_level(res);
    row = ofs >> res;
    col = ofs & ((64'd1 << res) - 64'd1);
    // Walk up from the pixel's own level to level 0, halving row and column each step.
    for (int i = int'(res); i >= 0; i--) begin
      sh = res - i;
      anc = first_pixel_of_level(i) + ((row >> sh) << i) + (col >> sh);
      word.pixel   = anc[ParW-1:0];
      word.lvl     = i[LvlW-1:0];
      word.err     = 1'b0;
      word.is_last = (i == 0);
      expected_ancestors.push_back(word);
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  // Random pixel: mostly well-formed pixels at a random level, some noise.
  function automatic logic [31:0] pick_pixel();
    int unsigned     kind;
    int unsigned     res;
    longint unsigned mask, ofs, p;
    kind = $urandom_range(99);
    if (kind < 6) begin
      // Any 32-bit word: mostly negative or past the top level.
      p = {32'd0, $urandom};
    end else if (kind < 10) begin
      // Past the top level but still positive.
      p = first_pixel_of_level(TopRes + 1) +
          $urandom_range(32'h7FFF_FFFF - 32'd1431655765);
    end else begin
      res  = $urandom_range(TopRes);
      mask = (64'd1 << (2 * res)) - 64'd1;
      if (kind < 20) begin
        // Corners of the level grid: first, last, end of the first row.
        case ($urandom_range(2))
          0: ofs = 0;
          1: ofs = mask;
          default: ofs = (64'd1 << res) - 64'd1;
        endcase
      end else begin
        ofs = {$urandom, $urandom} & mask;
      end
      p = first_pixel_of_level(res) + ofs;
    end
    return p[31:0];
  endfunction

  // Offer one pixel and return at the clock edge that takes it. Valid stays high
  // on return: the caller either sends again or calls drain_results in the same step.
  task automatic send_pixel(input logic [31:0] pix);
    int unsigned gap;
    gap = 0;
    if (gaps_enabled) while ($urandom_range(99) < 14) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    child_pixel_i <= pix;
    // Sample stall at the falling edge; the next rising edge takes the word if low.
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predict_chain(pix);
  endtask

  // Drop valid and wait for every owed word to come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_ancestors.size() != 0) @(posedge clk_i);
  endtask

  // Write the scheme register; call only while the block is idle.
  task automatic write_scheme(input logic [SchemeW-1:0] value);
    pixel_scheme_we_i <= 1'b1;
    pixel_scheme_i    <= value;
    @(posedge clk_i);
    pixel_scheme_we_i <= 1'b0;
    scheme_setting = value;
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldOffCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= gaps_enabled && ($urandom_range(99) < 14);
    end
  end

  // Check each word the receiver takes against the oldest owed word. Outputs and
  // stall are settled by the falling edge, so this sees what the next rising edge takes.
  always @(negedge clk_i) begin
    ancestor_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ancestors.size() == 0) begin
        note_failure($sformatf("unexpected word pixel=%0d level=%0d err=%b last=%b",
                               parent_pixel_o, level_o, error_o, last_o));
      end else begin
        want = expected_ancestors.pop_front();
        if (parent_pixel_o !== want.pixel || level_o !== want.lvl ||
            error_o !== want.err || last_o !== want.is_last) begin
          note_failure($sformatf(
            "expected pixel=%0d level=%0d err=%b last=%b, got pixel=%0d level=%0d err=%b last=%b",
            want.pixel, want.lvl, want.err, want.is_last,
            parent_pixel_o, level_o, error_o, last_o));
        end
      end
    end
  end

  // Level boundaries, the largest legal pixel and the out-of-range neighbors.
  task automatic test_level_boundaries();
    int unsigned edge_levels[5];
    edge_levels = '{0, 1, 2, 7, TopRes};
    foreach (edge_levels[k]) begin
      send_pixel(32'(first_pixel_of_level(edge_levels[k])));
      send_pixel(32'(first_pixel_of_level(edge_levels[k] + 1) - 1));
    end
    // Last column of the first row at the top level.
    send_pixel(32'(first_pixel_of_level(TopRes) + (64'd1 << TopRes) - 1));
    send_pixel(32'(first_pixel_of_level(TopRes + 1)));
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
    send_pixel(32'hFFFF_FFFF);
    drain_results();
  endtask

  // Every scheme other than simple turns any pixel into an error word.
  task automatic test_scheme_settings();
    logic [SchemeW-1:0] odd_schemes[3];
    odd_schemes = '{SCHEME_HIER, SCHEME_UNKNOWN, SCHEME_RESERVED};
    foreach (odd_schemes[k]) begin
      write_scheme(odd_schemes[k]);
      send_pixel(32'd0);
      send_pixel(32'(first_pixel_of_level(TopRes + 1) - 1));
      send_pixel(32'hFFFF_FFFF);
      repeat (6) send_pixel(pick_pixel());
      drain_results();
    end
    write_scheme(SCHEME_SIMPLE);
  endtask

  // Bulk random chains: idling, a full-rate stretch, and a pause until drained.
  task automatic test_random_chains();
    repeat (100) send_pixel(pick_pixel());
    gaps_enabled = 1'b0;
    repeat (80) send_pixel(pick_pixel());
    gaps_enabled = 1'b1;
    // Hold the sender until the block has handed out everything.
    drain_results();
    repeat (80) send_pixel(pick_pixel());
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_output_holdoff();
    hold_request = 1'b1;
    repeat (60) send_pixel(pick_pixel());
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_level_boundaries();
    test_scheme_settings();
    test_random_chains();
    test_output_holdoff();
    // Give the block time to show any stray word after the last chain.
    repeat (ChainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** pixel_parent_chain_generator_core: PASSED **");
    end else begin
      $display("** pixel_parent_chain_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
